[design/ucep_pkg.sv]
// Shared types and constants for the control endpoint zero sequencer.
// Holds operation, handshake and stage codes and the queued and result word layouts.
// No dependencies.
package ucep_pkg;

    localparam int unsigned MpsW  = 7;
    localparam int unsigned LenW  = 16;
    localparam int unsigned CntW  = 10;
    localparam int unsigned AddrW = 7;
    localparam int unsigned DirBit = 7;

    localparam logic [7:0] ReqSetAddress = 8'd5;

    localparam logic CfgMaxPacketSize   = 1'b0;
    localparam logic CfgOutBufferLength = 1'b1;

    typedef enum logic [1:0] {
        OP_SETUP     = 2'd0,
        OP_IN_DONE   = 2'd1,
        OP_OUT_RX    = 2'd2,
        OP_BUS_RESET = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        HS_NAK   = 2'd0,
        HS_VALID = 2'd1,
        HS_STALL = 2'd2
    } t_hs;

    typedef enum logic [2:0] {
        ST_IDLE            = 3'd0,
        ST_STALLED         = 3'd1,
        ST_IN_DATA         = 3'd2,
        ST_IN_LAST         = 3'd3,
        ST_WAIT_STATUS_IN  = 3'd4,
        ST_WAIT_STATUS_OUT = 3'd5,
        ST_OUT_DATA        = 3'd6,
        ST_OUT_LAST        = 3'd7
    } t_stage;

    typedef struct packed {
        t_op              op;
        logic             zero_len;
        logic             dir_in;
        logic             set_addr;
        logic [AddrW-1:0] addr_val;
        logic [LenW-1:0]  xfer_len;
        logic [CntW-1:0]  out_count;
    } t_item;

    typedef struct packed {
        t_hs              tx;
        t_hs              rx;
        logic [MpsW-1:0]  tx_cnt;
        logic [CntW-1:0]  acc;
        logic [AddrW-1:0] address;
        logic             done;
        t_stage           stage;
    } t_result;

endpackage

[design/ucep_front.sv]
// Front end: accepts event words and classifies them for the queue.
// Precomputes the data stage length of a setup word. Uses ucep_pkg.
module ucep_front (
    input  logic                       i_valid,
    input  logic [1:0]                 i_operation,
    input  logic [7:0]                 i_request_type,
    input  logic [7:0]                 i_request_code,
    input  logic [15:0]                i_request_value,
    input  logic [15:0]                i_request_length,
    input  logic [15:0]                i_reply_length,
    input  logic [9:0]                 i_out_count,
    input  logic [ucep_pkg::LenW-1:0]  i_out_buffer_length,
    input  logic                       i_queue_full,
    output logic                       o_stall,
    output logic                       o_push,
    output ucep_pkg::t_item            o_item
);
    import ucep_pkg::*;

    logic [LenW-1:0] w_limit;

    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    always_comb begin
        w_limit = i_request_type[DirBit] ? i_reply_length : i_out_buffer_length;
        o_item.op        = t_op'(i_operation);
        o_item.zero_len  = (i_request_length == '0);
        o_item.dir_in    = i_request_type[DirBit];
        o_item.set_addr  = (i_request_type == '0) && (i_request_code == ReqSetAddress);
        o_item.addr_val  = i_request_value[AddrW-1:0];
        o_item.xfer_len  = (i_request_length < w_limit) ? i_request_length : w_limit;
        o_item.out_count = i_out_count;
    end

endmodule

[design/ucep_queue.sv]
// Short word queue between front and back end, held in flip-flops.
// Uses ucep_pkg for the word layout.
module ucep_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ucep_pkg::t_item i_item,
    input  logic            i_pop,
    output ucep_pkg::t_item o_item,
    output logic            o_full,
    output logic            o_empty
);
    import ucep_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    t_item           r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [PtrW-1:0] n_wr_ptr;
    logic [PtrW-1:0] n_rd_ptr;
    logic [CntW-1:0] n_count;

    assign o_full  = (r_count == FullCnt);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue pop while empty");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance on push");
`endif

endmodule

[design/ucep_back.sv]
// Back end: control transfer state machine and registered result word.
// Pops classified words from ucep_queue. Uses ucep_pkg.
module ucep_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ucep_pkg::MpsW-1:0]  i_max_packet_size,
    input  ucep_pkg::t_item            i_item,
    input  logic                       i_empty,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output ucep_pkg::t_result          o_result
);
    import ucep_pkg::*;

    t_stage           r_stage;
    t_stage           n_stage;
    logic [LenW-1:0]  r_rem;
    logic [LenW-1:0]  n_rem;
    logic             r_set_addr;
    logic             n_set_addr;
    logic [AddrW-1:0] r_addr_val;
    logic [AddrW-1:0] n_addr_val;
    logic [AddrW-1:0] r_address;
    logic [AddrW-1:0] n_address;
    logic             r_out_valid;
    logic             n_out_valid;
    t_result          r_out;
    t_result          n_out;

    logic [LenW-1:0]  w_mps;
    logic [LenW-1:0]  w_pkt_src;
    logic [MpsW-1:0]  w_pkt_len;
    logic [LenW-1:0]  w_pkt_rest;
    t_stage           w_pkt_stage;
    logic [CntW-1:0]  w_out_acc;
    logic [LenW-1:0]  w_out_rest;

    assign o_pop    = !i_empty && (!r_out_valid || !i_stall);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        w_mps       = {{(LenW-MpsW){1'b0}}, i_max_packet_size};
        w_pkt_src   = (i_item.op == OP_SETUP) ? i_item.xfer_len : r_rem;
        w_pkt_len   = (w_pkt_src < w_mps) ? w_pkt_src[MpsW-1:0] : i_max_packet_size;
        w_pkt_rest  = w_pkt_src - {{(LenW-MpsW){1'b0}}, w_pkt_len};
        w_pkt_stage = ((w_pkt_rest == '0) && (w_pkt_len != i_max_packet_size))
                      ? ST_IN_LAST : ST_IN_DATA;
        w_out_acc   = ({{(LenW-CntW){1'b0}}, i_item.out_count} < r_rem)
                      ? i_item.out_count : r_rem[CntW-1:0];
        w_out_rest  = r_rem - {{(LenW-CntW){1'b0}}, w_out_acc};

        n_stage    = r_stage;
        n_rem      = r_rem;
        n_set_addr = r_set_addr;
        n_addr_val = r_addr_val;
        n_address  = r_address;
        n_out      = r_out;
        n_out.tx     = HS_NAK;
        n_out.rx     = HS_NAK;
        n_out.tx_cnt = '0;
        n_out.acc    = '0;
        n_out.done   = 1'b0;

        if (o_pop) begin
            unique case (i_item.op)
                OP_SETUP: begin
                    n_set_addr = i_item.set_addr;
                    n_addr_val = i_item.addr_val;
                    priority if (i_item.zero_len) begin
                        n_out.tx = HS_VALID;
                        n_stage  = ST_WAIT_STATUS_IN;
                    end else if (i_item.dir_in) begin
                        n_rem        = w_pkt_rest;
                        n_stage      = w_pkt_stage;
                        n_out.tx_cnt = w_pkt_len;
                        n_out.tx     = HS_VALID;
                        if (w_pkt_stage == ST_IN_DATA) begin
                            n_out.rx = HS_STALL;
                        end
                    end else begin
                        n_rem    = i_item.xfer_len;
                        n_stage  = (i_item.xfer_len < w_mps) ? ST_OUT_LAST : ST_OUT_DATA;
                        n_out.rx = HS_VALID;
                    end
                end
                OP_IN_DONE: begin
                    priority if (r_stage == ST_WAIT_STATUS_IN) begin
                        if (r_set_addr) begin
                            n_address = r_addr_val;
                        end
                        n_out.tx   = HS_STALL;
                        n_out.rx   = HS_STALL;
                        n_out.done = 1'b1;
                        n_stage    = ST_IDLE;
                    end else if (r_stage == ST_IN_LAST) begin
                        n_stage  = ST_WAIT_STATUS_OUT;
                        n_out.rx = HS_VALID;
                    end else begin
                        n_rem        = w_pkt_rest;
                        n_stage      = w_pkt_stage;
                        n_out.tx_cnt = w_pkt_len;
                        n_out.tx     = HS_VALID;
                        if (w_pkt_stage == ST_IN_DATA) begin
                            n_out.rx = HS_STALL;
                        end
                    end
                end
                OP_OUT_RX: begin
                    priority if (r_stage == ST_WAIT_STATUS_OUT) begin
                        n_stage    = ST_IDLE;
                        n_out.rx   = HS_VALID;
                        n_out.done = 1'b1;
                    end else if (r_stage == ST_IN_DATA || r_stage == ST_IN_LAST) begin
                        n_stage  = ST_STALLED;
                        n_out.tx = HS_STALL;
                        n_out.rx = HS_STALL;
                    end else begin
                        n_out.acc = w_out_acc;
                        n_rem     = w_out_rest;
                        if (r_stage == ST_OUT_LAST) begin
                            n_stage  = ST_WAIT_STATUS_IN;
                            n_out.tx = HS_VALID;
                        end else begin
                            if (w_out_rest < w_mps) begin
                                n_stage = ST_OUT_LAST;
                            end
                            n_out.rx = HS_VALID;
                        end
                    end
                end
                OP_BUS_RESET: begin
                    n_stage   = ST_IDLE;
                    n_address = '0;
                end
            endcase
            n_out.stage   = n_stage;
            n_out.address = n_address;
        end

        if (o_pop) begin
            n_out_valid = 1'b1;
        end else if (i_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= ST_IDLE;
            r_rem       <= '0;
            r_set_addr  <= 1'b0;
            r_addr_val  <= '0;
            r_address   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_stage     <= n_stage;
            r_rem       <= n_rem;
            r_set_addr  <= n_set_addr;
            r_addr_val  <= n_addr_val;
            r_address   <= n_address;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done) |-> (r_out.stage == ST_IDLE))
        else $error("status done without return to idle");
    a_count_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.tx_cnt != '0) |-> (r_out.tx == HS_VALID))
        else $error("tx byte count without valid tx");
    a_acc_hs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.acc != '0) |-> (r_out.rx == HS_VALID || r_out.tx == HS_VALID))
        else $error("accepted bytes without valid handshake");
`endif

endmodule

[design/usb_control_endpoint_sequencer_top.sv]
// Control endpoint zero sequencer, top level: config registers, front end,
// word queue and back end. Uses ucep_pkg, ucep_front, ucep_queue, ucep_back.
// An accepted event word passes through the queue and then the result register before o_valid rises.
// Throughput: one event word per cycle while i_stall is low and the queue is not full.
// Reset: synchronous active-low; stage idle, address 0, queue and output empty,
// max_packet_size and out_buffer_length return to 64.
module usb_control_endpoint_sequencer_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_request_type,
    input  logic [7:0]  i_request_code,
    input  logic [15:0] i_request_value,
    input  logic [15:0] i_request_length,
    input  logic [15:0] i_reply_length,
    input  logic [9:0]  i_out_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_tx_handshake,
    output logic [1:0]  o_rx_handshake,
    output logic [6:0]  o_tx_byte_count,
    output logic [9:0]  o_accepted_bytes,
    output logic [6:0]  o_device_address,
    output logic        o_request_done,
    output logic [2:0]  o_stage
);
    import ucep_pkg::*;

    logic [MpsW-1:0] r_max_packet_size;
    logic [LenW-1:0] r_out_buffer_length;

    logic    w_push;
    logic    w_pop;
    logic    w_full;
    logic    w_empty;
    t_item   w_front_item;
    t_item   w_back_item;
    t_result w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_packet_size   <= MpsW'(64);
            r_out_buffer_length <= LenW'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgMaxPacketSize:   r_max_packet_size   <= i_cfg_data[MpsW-1:0];
                CfgOutBufferLength: r_out_buffer_length <= i_cfg_data[LenW-1:0];
            endcase
        end
    end

    ucep_front u_front (
        .i_valid             (i_valid),
        .i_operation         (i_operation),
        .i_request_type      (i_request_type),
        .i_request_code      (i_request_code),
        .i_request_value     (i_request_value),
        .i_request_length    (i_request_length),
        .i_reply_length      (i_reply_length),
        .i_out_count         (i_out_count),
        .i_out_buffer_length (r_out_buffer_length),
        .i_queue_full        (w_full),
        .o_stall             (o_stall),
        .o_push              (w_push),
        .o_item              (w_front_item)
    );

    ucep_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_back_item),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    ucep_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_max_packet_size (r_max_packet_size),
        .i_item            (w_back_item),
        .i_empty           (w_empty),
        .o_pop             (w_pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_result          (w_result)
    );

    assign o_tx_handshake   = w_result.tx;
    assign o_rx_handshake   = w_result.rx;
    assign o_tx_byte_count  = w_result.tx_cnt;
    assign o_accepted_bytes = w_result.acc;
    assign o_device_address = w_result.address;
    assign o_request_done   = w_result.done;
    assign o_stage          = w_result.stage;

endmodule

[tb/usb_control_endpoint_sequencer_top_tb.sv]
// Self-checking testbench for usb_control_endpoint_sequencer_top: directed and
// randomised control transfers, checked word by word against an in-bench predictor.
// Depends on ucep_pkg and the design files under design/.
module usb_control_endpoint_sequencer_top_tb;
    import ucep_pkg::*;

    typedef struct packed {
        t_op         op;
        logic [7:0]  rtype;
        logic [7:0]  rcode;
        logic [15:0] rvalue;
        logic [15:0] rlength;
        logic [15:0] reply;
        logic [9:0]  ocount;
    } t_ctrl_event;

    localparam int unsigned WatchdogLimit = 3000;
    localparam int unsigned ItemsPerPhase = 325;
    localparam int unsigned NumPhases     = 6;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_we         = 1'b0;
    logic        i_cfg_index      = CfgMaxPacketSize;
    logic [15:0] i_cfg_data       = '0;
    logic        i_valid          = 1'b0;
    logic        o_stall;
    logic [1:0]  i_operation      = OP_SETUP;
    logic [7:0]  i_request_type   = '0;
    logic [7:0]  i_request_code   = '0;
    logic [15:0] i_request_value  = '0;
    logic [15:0] i_request_length = '0;
    logic [15:0] i_reply_length   = '0;
    logic [9:0]  i_out_count      = '0;
    logic        o_valid;
    logic        i_stall          = 1'b0;
    logic [1:0]  o_tx_handshake;
    logic [1:0]  o_rx_handshake;
    logic [6:0]  o_tx_byte_count;
    logic [9:0]  o_accepted_bytes;
    logic [6:0]  o_device_address;
    logic        o_request_done;
    logic [2:0]  o_stage;

    usb_control_endpoint_sequencer_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_operation      (i_operation),
        .i_request_type   (i_request_type),
        .i_request_code   (i_request_code),
        .i_request_value  (i_request_value),
        .i_request_length (i_request_length),
        .i_reply_length   (i_reply_length),
        .i_out_count      (i_out_count),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_tx_handshake   (o_tx_handshake),
        .o_rx_handshake   (o_rx_handshake),
        .o_tx_byte_count  (o_tx_byte_count),
        .o_accepted_bytes (o_accepted_bytes),
        .o_device_address (o_device_address),
        .o_request_done   (o_request_done),
        .o_stage          (o_stage)
    );

    // endpoint shadow state
    logic [6:0]  cfg_mps     = 7'd64;
    logic [15:0] cfg_obl     = 16'd64;
    t_stage      ep_stage    = ST_IDLE;
    logic [15:0] ep_remain   = '0;
    logic [7:0]  ep_type     = '0;
    logic [7:0]  ep_code     = '0;
    logic [15:0] ep_value    = '0;
    logic [6:0]  ep_address  = '0;

    t_ctrl_event pending_events[$];
    t_result     expected_replies[$];
    t_ctrl_event ev_on_bus;
    t_result     reply_word;

    int unsigned gap_pct      = 0;
    int unsigned stall_pct    = 0;
    int unsigned events_sent  = 0;
    int unsigned replies_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned orphans      = 0;
    int unsigned idle_cycles  = 0;

    function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [6:0] load_in_packet();
        logic [15:0] len;
        len = min16(ep_remain, {9'd0, cfg_mps});
        ep_remain = ep_remain - len;
        if (ep_remain == 16'd0 && len != {9'd0, cfg_mps}) begin
            ep_stage = ST_IN_LAST;
        end else begin
            ep_stage = ST_IN_DATA;
        end
        return len[6:0];
    endfunction

    function automatic t_result advance_endpoint(input t_ctrl_event ev);
        t_result     r;
        logic [15:0] taken;
        r = '0;
        case (ev.op)
            OP_SETUP: begin
                ep_type  = ev.rtype;
                ep_code  = ev.rcode;
                ep_value = ev.rvalue;
                if (ev.rlength == 16'd0) begin
                    r.tx = HS_VALID;
                    ep_stage = ST_WAIT_STATUS_IN;
                end else if (ev.rtype[DirBit]) begin
                    ep_remain = min16(ev.rlength, ev.reply);
                    r.tx_cnt = load_in_packet();
                    r.tx = HS_VALID;
                    if (ep_stage == ST_IN_DATA) r.rx = HS_STALL;
                end else begin
                    ep_remain = min16(ev.rlength, cfg_obl);
                    ep_stage = (ep_remain < {9'd0, cfg_mps}) ? ST_OUT_LAST : ST_OUT_DATA;
                    r.rx = HS_VALID;
                end
            end
            OP_IN_DONE: begin
                if (ep_stage == ST_WAIT_STATUS_IN) begin
                    if (ep_code == ReqSetAddress && ep_type == 8'd0) ep_address = ep_value[6:0];
                    r.rx = HS_STALL;
                    r.tx = HS_STALL;
                    ep_stage = ST_IDLE;
                    r.done = 1'b1;
                end else if (ep_stage == ST_IN_LAST) begin
                    ep_stage = ST_WAIT_STATUS_OUT;
                    r.rx = HS_VALID;
                end else begin
                    r.tx_cnt = load_in_packet();
                    r.tx = HS_VALID;
                    if (ep_stage == ST_IN_DATA) r.rx = HS_STALL;
                end
            end
            OP_OUT_RX: begin
                if (ep_stage == ST_WAIT_STATUS_OUT) begin
                    ep_stage = ST_IDLE;
                    r.rx = HS_VALID;
                    r.done = 1'b1;
                end else if (ep_stage == ST_IN_DATA || ep_stage == ST_IN_LAST) begin
                    ep_stage = ST_STALLED;
                    r.rx = HS_STALL;
                    r.tx = HS_STALL;
                end else begin
                    taken = min16({6'd0, ev.ocount}, ep_remain);
                    r.acc = taken[9:0];
                    ep_remain = ep_remain - taken;
                    if (ep_stage == ST_OUT_LAST) begin
                        ep_stage = ST_WAIT_STATUS_IN;
                        r.tx = HS_VALID;
                    end else begin
                        if (ep_remain < {9'd0, cfg_mps}) ep_stage = ST_OUT_LAST;
                        r.rx = HS_VALID;
                    end
                end
            end
            default: begin
                ep_stage = ST_IDLE;
                ep_address = '0;
            end
        endcase
        r.address = ep_address;
        r.stage = ep_stage;
        return r;
    endfunction

    task automatic queue_event(input t_op op, input logic [7:0] rt, input logic [7:0] rc,
                               input logic [15:0] rv, input logic [15:0] rl,
                               input logic [15:0] rp, input logic [9:0] oc);
        t_ctrl_event ev;
        ev.op = op;
        ev.rtype = rt;
        ev.rcode = rc;
        ev.rvalue = rv;
        ev.rlength = rl;
        ev.reply = rp;
        ev.ocount = oc;
        pending_events.push_back(ev);
    endtask

    task automatic queue_simple(input t_op op, input logic [9:0] oc);
        queue_event(op, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), oc);
    endtask

    function automatic logic [15:0] pick_length();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) return 16'($urandom_range(1, 200));
        if (sel < 70) return 16'(cfg_mps * $urandom_range(1, 4));
        if (sel < 85) return {9'd0, cfg_mps};
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic int unsigned packet_estimate(input logic [15:0] bytes);
        int unsigned n;
        if (cfg_mps == 7'd0) return $urandom_range(1, 4);
        n = bytes / cfg_mps + 2;
        if (n > 10) n = $urandom_range(3, 10);
        return n;
    endfunction

    task automatic queue_random_traffic(input int unsigned target);
        int unsigned sel;
        int unsigned n;
        logic [15:0] len;
        logic [15:0] rep;
        while (pending_events.size() < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                len = pick_length();
                rep = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                  : pick_length();
                queue_event(OP_SETUP, 8'h80 | 8'($urandom_range(0, 127)), 8'($urandom),
                            16'($urandom), len, rep, 10'($urandom));
                n = packet_estimate(min16(len, rep));
                repeat (n) begin
                    if ($urandom_range(0, 19) == 0) queue_simple(OP_OUT_RX, 10'($urandom));
                    queue_simple(OP_IN_DONE, 10'($urandom));
                end
                queue_simple(OP_OUT_RX, 10'($urandom_range(0, 3)));
            end else if (sel < 62) begin
                len = pick_length();
                queue_event(OP_SETUP, 8'($urandom_range(0, 127)), 8'($urandom),
                            16'($urandom), len, 16'($urandom), 10'($urandom));
                n = packet_estimate(min16(len, cfg_obl));
                repeat (n) begin
                    queue_simple(OP_OUT_RX, ($urandom_range(0, 3) == 0) ?
                                 10'($urandom_range(0, 1023)) : {3'd0, cfg_mps});
                end
                queue_simple(OP_IN_DONE, 10'($urandom));
            end else if (sel < 75) begin
                if ($urandom_range(0, 1) == 0) begin
                    queue_event(OP_SETUP, 8'd0, ReqSetAddress, 16'($urandom), 16'd0,
                                16'($urandom), 10'($urandom));
                end else begin
                    queue_event(OP_SETUP, 8'($urandom), 8'($urandom_range(0, 12)),
                                16'($urandom), 16'd0, 16'($urandom), 10'($urandom));
                end
                if ($urandom_range(0, 9) == 0) queue_simple(OP_OUT_RX, 10'($urandom));
                queue_simple(OP_IN_DONE, 10'($urandom));
            end else if (sel < 80) begin
                queue_simple(OP_BUS_RESET, 10'($urandom));
            end else begin
                queue_simple(t_op'($urandom_range(0, 3)), 10'($urandom));
            end
        end
    endtask

    task automatic queue_directed();
        // IN and OUT straight out of reset, then stall recovery
        queue_event(OP_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 10'd0);
        queue_event(OP_OUT_RX,  8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 10'd0);
        queue_event(OP_OUT_RX,  8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 10'd5);
        // set address with every value bit high
        queue_event(OP_SETUP,   8'h00, ReqSetAddress, 16'hFFFF, 16'h0000, 16'h0000, 10'd0);
        queue_event(OP_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 10'd0);
        // full last packet, so a zero-length packet follows
        queue_event(OP_SETUP,   8'hFF, 8'hFF, 16'h0000, 16'hFFFF, 16'd64, 10'h3FF);
        queue_event(OP_IN_DONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF);
        queue_event(OP_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 10'd0);
        queue_event(OP_OUT_RX,  8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 10'h3FF);
        // short last packet
        queue_event(OP_SETUP,   8'h80, 8'h06, 16'h0100, 16'd100, 16'hFFFF, 10'd0);
        queue_event(OP_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 10'd0);
        queue_event(OP_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 10'd0);
        queue_event(OP_OUT_RX,  8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 10'd0);
        // control write clipped to the buffer
        queue_event(OP_SETUP,   8'h00, 8'h00, 16'h0000, 16'hFFFF, 16'h0000, 10'd0);
        queue_event(OP_OUT_RX,  8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 10'h3FF);
        queue_event(OP_OUT_RX,  8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 10'd0);
        queue_event(OP_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 10'd0);
        queue_event(OP_OUT_RX,  8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 10'd5);
        queue_event(OP_BUS_RESET, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF);
        // bus reset before the address takes effect
        queue_event(OP_SETUP,   8'h00, ReqSetAddress, 16'h0042, 16'h0000, 16'h0000, 10'd0);
        queue_event(OP_BUS_RESET, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 10'd0);
        // set address code with a non-standard request type
        queue_event(OP_SETUP,   8'h7F, ReqSetAddress, 16'h0011, 16'h0000, 16'h0000, 10'd0);
        queue_event(OP_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 10'd0);
        // OUT while waiting for the IN status
        queue_event(OP_SETUP,   8'h21, 8'h09, 16'h0200, 16'h0000, 16'h0000, 10'd0);
        queue_event(OP_OUT_RX,  8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 10'd3);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == CfgMaxPacketSize) begin
            cfg_mps = val[6:0];
        end else begin
            cfg_obl = val;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch on word %0d, %s: expected %0d, got %0d",
                     replies_seen, name, want, got);
        end
    endtask

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // driver: hold a stalled word, otherwise advance or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_replies.push_back(advance_endpoint(ev_on_bus));
                events_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_events.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
                    ev_on_bus = pending_events.pop_front();
                    i_operation      <= ev_on_bus.op;
                    i_request_type   <= ev_on_bus.rtype;
                    i_request_code   <= ev_on_bus.rcode;
                    i_request_value  <= ev_on_bus.rvalue;
                    i_request_length <= ev_on_bus.rlength;
                    i_reply_length   <= ev_on_bus.reply;
                    i_out_count      <= ev_on_bus.ocount;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_replies.size() == 0) begin
                    orphans++;
                    $display("result word %0d arrived with nothing expected", replies_seen);
                end else begin
                    reply_word = expected_replies.pop_front();
                    if (o_tx_handshake !== reply_word.tx)
                        report_field("tx_handshake", 32'(reply_word.tx),
                                     32'(o_tx_handshake));
                    if (o_rx_handshake !== reply_word.rx)
                        report_field("rx_handshake", 32'(reply_word.rx),
                                     32'(o_rx_handshake));
                    if (o_tx_byte_count !== reply_word.tx_cnt)
                        report_field("tx_byte_count", 32'(reply_word.tx_cnt),
                                     32'(o_tx_byte_count));
                    if (o_accepted_bytes !== reply_word.acc)
                        report_field("accepted_bytes", 32'(reply_word.acc),
                                     32'(o_accepted_bytes));
                    if (o_device_address !== reply_word.address)
                        report_field("device_address", 32'(reply_word.address),
                                     32'(o_device_address));
                    if (o_request_done !== reply_word.done)
                        report_field("request_done", 32'(reply_word.done),
                                     32'(o_request_done));
                    if (o_stage !== reply_word.stage)
                        report_field("stage", 32'(reply_word.stage), 32'(o_stage));
                end
                replies_seen++;
            end
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("no progress for %0d cycles", WatchdogLimit);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int unsigned phase = 0; phase < NumPhases; phase++) begin
            case (phase)
                1: begin
                    write_reg(CfgMaxPacketSize, 16'd8);
                    write_reg(CfgOutBufferLength, 16'd0);
                end
                2: begin
                    write_reg(CfgMaxPacketSize, 16'd64);
                    write_reg(CfgOutBufferLength, 16'hFFFF);
                end
                3: begin
                    write_reg(CfgMaxPacketSize, 16'd0);
                    write_reg(CfgOutBufferLength, 16'd200);
                end
                4: begin
                    write_reg(CfgMaxPacketSize, 16'd127);
                    write_reg(CfgOutBufferLength, 16'd1000);
                end
                5: begin
                    write_reg(CfgMaxPacketSize, 16'($urandom_range(8, 64)));
                    write_reg(CfgOutBufferLength, 16'($urandom_range(0, 65535)));
                end
                default: ;
            endcase
            @(negedge i_clk);
            case (phase)
                1:       begin gap_pct = 74; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 74; end
                3, 5:    begin gap_pct = 20; stall_pct = 20; end
                default: begin gap_pct = 0;  stall_pct = 0;  end
            endcase
            if (phase == 0) queue_directed();
            queue_random_traffic(ItemsPerPhase);
            while (pending_events.size() > 0 || i_valid || expected_replies.size() > 0)
                @(negedge i_clk);
            repeat (4) @(negedge i_clk);
        end
        repeat (10) @(negedge i_clk);
        $display("Sent %0d control events over %0d size/buffer settings and idle patterns,",
                 events_sent, NumPhases);
        $display("checked %0d result words, %0d field mismatches, %0d unexpected words",
                 replies_seen, mismatches, orphans);
        if (mismatches == 0 && orphans == 0 && expected_replies.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
